// ===== hw/rtl/crc8_frame_receiver_unit_assert.svh =====
// assertion macros for the crc8 frame receiver
// used by crc8_frame_receiver_unit.sv, no other dependencies
`ifndef CRC8_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define CRC8_FRAME_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define CRC8FR_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("crc8fr assertion failed");

`define CRC8FR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc8fr implication failed");

`define CRC8FR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc8fr next-cycle check failed");

`else

`define CRC8FR_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define CRC8FR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define CRC8FR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/crc8fr_pkg.sv =====
// types, constants and crc-8 step function for the crc8 frame receiver
// no dependencies
`default_nettype none

package crc8fr_pkg;

    localparam logic [7:0]  START_BYTE    = 8'hAA;
    localparam logic [7:0]  END_BYTE      = 8'h55;
    localparam logic [7:0]  CRC_POLY      = 8'h07;
    localparam logic [7:0]  CRC_TOP       = 8'h80;
    localparam int          FRAME_LEN     = 13;
    localparam int          COUNT_W       = 4;
    localparam logic [7:0]  LEN_BYTE      = 8'(FRAME_LEN);
    localparam logic [COUNT_W-1:0] LAST_IDX = COUNT_W'(FRAME_LEN - 1);
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_BADLEN  = 3'd2,
        ST_BADEND  = 3'd3,
        ST_BADCRC  = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_LEN     = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_CRC     = 5'b01000,
        PH_END     = 5'b10000
    } phase_t;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  sender_id;
        logic [31:0] record_id;
        logic [31:0] volume_bits;
        logic [31:0] timestamp;
    } out_word_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if ((c & CRC_TOP) != 8'd0)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc8_frame_receiver_unit.sv =====
// crc8 frame receiver top level: framing fsm, crc-8, payload store, output skid
// depends on crc8fr_pkg and crc8_frame_receiver_unit_assert.svh
//
// Takes one word per cycle while in_stall is low, each a received byte or
// a timer tick, and hunts for frames of start byte 0xAA, length 13, 13 payload
// bytes, crc-8 (poly 0x07, init 0) and end byte 0x55. Every word is handled in
// the cycle it is accepted by the single-cycle phase and crc-8 logic; a result
// (status and unpacked fields) appears on out_valid the cycle after the word that
// ends a frame attempt, unless earlier results wait in the output register.
// An output register plus one skid entry buffer results, so in_stall rises only when
// both hold results that the receiver has not taken. cfg_wdata sets the per-phase
// tick timeout (reset 1000); the user must write it only while idle, not enforced.
`default_nettype none

`include "crc8_frame_receiver_unit_assert.svh"

module crc8_frame_receiver_unit
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire crc8fr_pkg::in_word_t in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output crc8fr_pkg::out_word_t     out_data,
    input  wire logic                 cfg_wen,
    input  wire logic [15:0]          cfg_wdata
);

    crc8fr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [crc8fr_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  rcv_crc_reg, rcv_crc_next;
    logic [15:0] timeout_reg;
    logic [7:0]  store_reg [crc8fr_pkg::FRAME_LEN];

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    crc8fr_pkg::out_word_t out_data_reg, out_data_next;
    crc8fr_pkg::out_word_t skid_data_reg, skid_data_next;

    logic        in_fire;
    logic        store_we;
    logic        res_valid;
    crc8fr_pkg::out_word_t res_word;
    logic [15:0] ticks_inc;
    logic [7:0]  rx;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign rx        = in_data.rx_byte;
    assign ticks_inc = (elapsed_reg == crc8fr_pkg::TICKS_MAX) ? elapsed_reg : elapsed_reg + 16'd1;

    // frame fsm
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        rcv_crc_next = rcv_crc_reg;
        store_we     = 1'b0;
        res_valid    = 1'b0;
        res_word     = '0;
        res_word.status = crc8fr_pkg::ST_OK;

        if (in_fire)
        begin
            if (in_data.cmd == crc8fr_pkg::CMD_TICK)
            begin
                elapsed_next = ticks_inc;
                if (ticks_inc >= timeout_reg)
                begin
                    res_valid       = 1'b1;
                    res_word.status = crc8fr_pkg::ST_TIMEOUT;
                end
            end
            else
            begin
                unique case (phase_reg)
                    crc8fr_pkg::PH_HUNT:
                    begin
                        if (rx == crc8fr_pkg::START_BYTE)
                        begin
                            phase_next   = crc8fr_pkg::PH_LEN;
                            elapsed_next = '0;
                            count_next   = '0;
                            crc_next     = crc8fr_pkg::crc8_step(8'd0, rx);
                        end
                    end
                    crc8fr_pkg::PH_LEN:
                    begin
                        if (rx != crc8fr_pkg::LEN_BYTE)
                        begin
                            res_valid       = 1'b1;
                            res_word.status = crc8fr_pkg::ST_BADLEN;
                        end
                        else
                        begin
                            crc_next     = crc8fr_pkg::crc8_step(crc_reg, rx);
                            phase_next   = crc8fr_pkg::PH_PAYLOAD;
                            elapsed_next = '0;
                            count_next   = '0;
                        end
                    end
                    crc8fr_pkg::PH_PAYLOAD:
                    begin
                        store_we   = 1'b1;
                        crc_next   = crc8fr_pkg::crc8_step(crc_reg, rx);
                        count_next = count_reg + 1'b1;
                        if (count_reg == crc8fr_pkg::LAST_IDX)
                        begin
                            phase_next   = crc8fr_pkg::PH_CRC;
                            elapsed_next = '0;
                        end
                    end
                    crc8fr_pkg::PH_CRC:
                    begin
                        rcv_crc_next = rx;
                        phase_next   = crc8fr_pkg::PH_END;
                        elapsed_next = '0;
                    end
                    crc8fr_pkg::PH_END:
                    begin
                        res_valid = 1'b1;
                        if (rx != crc8fr_pkg::END_BYTE)
                        begin
                            res_word.status = crc8fr_pkg::ST_BADEND;
                        end
                        else if (crc_reg != rcv_crc_reg)
                        begin
                            res_word.status = crc8fr_pkg::ST_BADCRC;
                        end
                        else
                        begin
                            res_word.status      = crc8fr_pkg::ST_OK;
                            res_word.sender_id   = store_reg[0];
                            res_word.record_id   = {store_reg[1], store_reg[2],
                                                    store_reg[3], store_reg[4]};
                            res_word.volume_bits = {store_reg[8], store_reg[7],
                                                    store_reg[6], store_reg[5]};
                            res_word.timestamp   = {store_reg[9], store_reg[10],
                                                    store_reg[11], store_reg[12]};
                        end
                    end
                    default:
                    begin
                        phase_next = crc8fr_pkg::PH_HUNT;
                    end
                endcase
            end

            // any result ends the attempt
            if (res_valid)
            begin
                phase_next   = crc8fr_pkg::PH_HUNT;
                elapsed_next = '0;
                count_next   = '0;
                crc_next     = '0;
            end
        end
    end

    // output register and skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res_word;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= crc8fr_pkg::PH_HUNT;
            elapsed_reg    <= '0;
            count_reg      <= '0;
            crc_reg        <= '0;
            rcv_crc_reg    <= '0;
            timeout_reg    <= crc8fr_pkg::TIMEOUT_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            rcv_crc_reg    <= rcv_crc_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_wen)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
        for (int i = 0; i < crc8fr_pkg::FRAME_LEN; i++)
        begin
            if (store_we && (count_reg == crc8fr_pkg::COUNT_W'(i)))
            begin
                store_reg[i] <= rx;
            end
        end
    end

    `CRC8FR_ASSERT_ALWAYS(a_skid_behind_out, clk, rst_n, !skid_valid_reg || out_valid_reg)
    `CRC8FR_ASSERT_IMPLY(a_count_in_range, clk, rst_n,
        phase_reg == crc8fr_pkg::PH_PAYLOAD, count_reg <= crc8fr_pkg::LAST_IDX)
    `CRC8FR_ASSERT_IMPLY(a_err_fields_zero, clk, rst_n,
        out_valid_reg && (out_data_reg.status != crc8fr_pkg::ST_OK),
        (out_data_reg.sender_id == 8'd0) && (out_data_reg.record_id == 32'd0) &&
        (out_data_reg.volume_bits == 32'd0) && (out_data_reg.timestamp == 32'd0))
    `CRC8FR_ASSERT_NEXT(a_end_to_hunt, clk, rst_n,
        in_fire && (in_data.cmd == crc8fr_pkg::CMD_BYTE) && (phase_reg == crc8fr_pkg::PH_END),
        (phase_reg == crc8fr_pkg::PH_HUNT) && out_valid_reg)

endmodule

`default_nettype wire
